@@ design/ggdc_pkg.sv @@
package ggdc_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int FRAC_BITS    = 4;
   localparam int GUARD_BITS   = 8;
   localparam int ANG_FRAC     = 16;
   localparam int INV_GAIN_Q16 = 39797;

   localparam int CMD_W      = 2;
   localparam int POS_W      = 12;
   localparam int HEAD_W     = 9;
   localparam int LIN_W      = 7;
   localparam int TURN_W     = 8;
   localparam int GAIN_W     = 16;
   localparam int SPEED_W    = 7;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DX_W       = POS_W + 1;
   localparam int XY_W       = DX_W + FRAC_BITS + GUARD_BITS + 3;
   localparam int Z_W        = 26;
   localparam int ATAN_W     = 22;
   localparam int ATAN_IDX_W = 5;
   localparam int CNT_W      = $clog2(CORDIC_STEPS);
   localparam int MB_W       = GAIN_W + 1;
   localparam int PROD_W     = XY_W + MB_W;
   localparam int DIST_W     = DX_W + FRAC_BITS;
   localparam int ERR_W      = FRAC_BITS + 11;
   localparam int V_W        = FRAC_BITS + LIN_W + 1;
   localparam int W_W        = FRAC_BITS + TURN_W + 1;
   localparam int WH_W       = FRAC_BITS + 11;

   localparam int MAG_SHIFT  = ANG_FRAC + GUARD_BITS;
   localparam int ANG_SHIFT  = ANG_FRAC - FRAC_BITS;
   localparam int GAIN_SHIFT = 8;
   localparam int HALF_TURN  = 180 * (1 << FRAC_BITS);
   localparam int FULL_TURN  = 360 * (1 << FRAC_BITS);
   localparam int WHEEL_LIM  = 200 * (1 << FRAC_BITS);
   localparam int QUARTER_Z  = 90 * (1 << ANG_FRAC);

   localparam logic [CMD_W-1:0] CMD_POSE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ARM   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_LIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TURN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIST_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEAD_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_X    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_Y    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_RAD  = 3'd6;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NO_GOAL = 3'd0,
      STAT_OFF_MAT = 3'd1,
      STAT_ARRIVED = 3'd2,
      STAT_DRIVING = 3'd3,
      STAT_ACK     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MAG,
      ST_CHECK,
      ST_WRAP,
      ST_VMUL,
      ST_WMUL,
      ST_MIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [LIN_W-1:0]  max_linear_speed;
      logic [TURN_W-1:0] max_turn_rate;
      logic [GAIN_W-1:0] distance_gain;
      logic [GAIN_W-1:0] heading_gain;
      logic [POS_W-1:0]  goal_x;
      logic [POS_W-1:0]  goal_y;
      logic [POS_W-1:0]  stop_radius;
   } cfg_type;

   typedef struct packed {
      logic                   done;
      logic signed [XY_W-1:0] x_mag;
      logic signed [Z_W-1:0]  z_ang;
   } cordic_res_type;

   // atan(2^-i) in degrees, q16
   function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      begin
         case (idx)
            5'd0:  val = 22'd2949120;
            5'd1:  val = 22'd1740967;
            5'd2:  val = 22'd919879;
            5'd3:  val = 22'd466945;
            5'd4:  val = 22'd234379;
            5'd5:  val = 22'd117304;
            5'd6:  val = 22'd58666;
            5'd7:  val = 22'd29335;
            5'd8:  val = 22'd14668;
            5'd9:  val = 22'd7334;
            5'd10: val = 22'd3667;
            5'd11: val = 22'd1833;
            5'd12: val = 22'd917;
            5'd13: val = 22'd458;
            5'd14: val = 22'd229;
            5'd15: val = 22'd115;
            5'd16: val = 22'd57;
            5'd17: val = 22'd29;
            5'd18: val = 22'd14;
            5'd19: val = 22'd7;
            5'd20: val = 22'd4;
            5'd21: val = 22'd2;
            5'd22: val = 22'd1;
            default: val = 22'd0;
         endcase
         return val;
      end
   endfunction

endpackage

@@ design/ggdc_if.sv @@
interface ggdc_req_if;
   logic                         valid;
   logic                         ready;
   logic [ggdc_pkg::CMD_W-1:0]   command;
   logic [ggdc_pkg::POS_W-1:0]   pos_x;
   logic [ggdc_pkg::POS_W-1:0]   pos_y;
   logic [ggdc_pkg::HEAD_W-1:0]  heading_deg;
   logic                         on_mat;

   modport source(output valid, command, pos_x, pos_y, heading_deg, on_mat, input ready);
   modport sink(input valid, command, pos_x, pos_y, heading_deg, on_mat, output ready);
endinterface

interface ggdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ggdc_pkg::STATUS_W-1:0] status;
   logic                          left_forward;
   logic [ggdc_pkg::SPEED_W-1:0]  left_mag;
   logic                          right_forward;
   logic [ggdc_pkg::SPEED_W-1:0]  right_mag;

   modport source(output valid, status, left_forward, left_mag, right_forward,
                  right_mag, input ready);
   modport sink(input valid, status, left_forward, left_mag, right_forward,
                right_mag, output ready);
endinterface

interface ggdc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ggdc_pkg::CSR_IDX_W-1:0]  index;
   logic [ggdc_pkg::CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ design/go_to_goal_diff_drive_controller_unit.sv @@
// channel   dir   handshake           payload
// req_bus   in    valid/ready         command, pos_x, pos_y, heading_deg, on_mat
// rsp_bus   out   valid/ready         status, left/right forward, left/right mag
// csr_bus   in    valid/ready (rdy=1) index, data
//
// commands, no-goal and off-mat poses set the result at accept and go straight to the load
// an arrived pose runs 16 steps of the cordic shift-add unit and one multiplier pass; a
// driving pose adds 1 to 3 heading wrap steps and two more passes through the multiplier
// the next request is taken the cycle after the load, and while a result waits on
// rsp_bus; a second finished result stalls the input until the first is accepted
// reset (synchronous, active high) clears goal flag, sequencer, result valid; sets csr defaults
module go_to_goal_diff_drive_controller_unit (
   input  logic        clock,
   input  logic        reset,
   ggdc_req_if.sink    req_bus,
   ggdc_rsp_if.source  rsp_bus,
   ggdc_csr_if.sink    csr_bus
);

   localparam int FB     = ggdc_pkg::FRAC_BITS;
   localparam int XY_W   = ggdc_pkg::XY_W;
   localparam int Z_W    = ggdc_pkg::Z_W;
   localparam int MB_W   = ggdc_pkg::MB_W;
   localparam int PROD_W = ggdc_pkg::PROD_W;
   localparam int DIST_W = ggdc_pkg::DIST_W;
   localparam int ERR_W  = ggdc_pkg::ERR_W;
   localparam int V_W    = ggdc_pkg::V_W;
   localparam int W_W    = ggdc_pkg::W_W;
   localparam int WH_W   = ggdc_pkg::WH_W;
   localparam int SP_W   = ggdc_pkg::SPEED_W;

   localparam logic signed [PROD_W-1:0] MAG_HALF  = PROD_W'(1) <<< (ggdc_pkg::MAG_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] GAIN_HALF = PROD_W'(1) <<< (ggdc_pkg::GAIN_SHIFT - 1);
   localparam logic signed [Z_W-1:0]    ANG_HALF  = Z_W'(1) <<< (ggdc_pkg::ANG_SHIFT - 1);
   localparam logic signed [ERR_W-1:0]  ERR_HALF  = ERR_W'(ggdc_pkg::HALF_TURN);
   localparam logic signed [ERR_W-1:0]  ERR_FULL  = ERR_W'(ggdc_pkg::FULL_TURN);
   localparam logic signed [WH_W-1:0]   WH_LIM    = WH_W'(ggdc_pkg::WHEEL_LIM);
   localparam logic signed [MB_W-1:0]   INV_GAIN  = MB_W'(ggdc_pkg::INV_GAIN_Q16);

   ggdc_pkg::cfg_type        cfg;
   ggdc_pkg::cordic_res_type cres;

   ggdc_pkg::state_type      state_ff, state_in;
   logic                     armed_ff, armed_in;
   logic [ggdc_pkg::HEAD_W-1:0] hd_ff, hd_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [V_W-1:0]    v_ff, v_in;
   ggdc_pkg::status_type     res_status_ff, res_status_in;
   logic                     res_lf_ff, res_lf_in;
   logic [SP_W-1:0]          res_ls_ff, res_ls_in;
   logic                     res_rf_ff, res_rf_in;
   logic [SP_W-1:0]          res_rs_ff, res_rs_in;
   logic                     out_valid_ff, out_valid_in;
   ggdc_pkg::status_type     out_status_ff, out_status_in;
   logic                     out_lf_ff, out_lf_in;
   logic [SP_W-1:0]          out_ls_ff, out_ls_in;
   logic                     out_rf_ff, out_rf_in;
   logic [SP_W-1:0]          out_rs_ff, out_rs_in;

   logic                     req_ready;
   logic                     req_acc;
   logic                     go_cordic;
   logic                     out_load;
   logic signed [ggdc_pkg::DX_W-1:0] dx;
   logic signed [ggdc_pkg::DX_W-1:0] dy;
   logic signed [XY_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] dist_full;
   logic [DIST_W-1:0]        dist_c;
   logic [DIST_W-1:0]        stop_c;
   logic signed [Z_W-1:0]    bearing;
   logic signed [ERR_W-1:0]  hd_c;
   logic                     arrived;
   logic signed [PROD_W-1:0] scaled;
   logic signed [PROD_W-1:0] vmax_c;
   logic signed [PROD_W-1:0] wmax_c;
   logic signed [W_W-1:0]    w_c;
   logic signed [WH_W-1:0]   left2;
   logic signed [WH_W-1:0]   right2;
   logic [SP_W:0]            left_enc;
   logic [SP_W:0]            right_enc;

   function automatic logic [SP_W:0] wheel_enc(input logic signed [WH_W-1:0] val);
      logic signed [WH_W-1:0] lim;
      logic [WH_W-1:0]        mag;
      begin
         lim = val;
         if (val > WH_LIM) begin
            lim = WH_LIM;
         end else if (val < -WH_LIM) begin
            lim = -WH_LIM;
         end
         mag = lim[WH_W-1] ? WH_W'(-lim) : WH_W'(lim);
         return {!lim[WH_W-1], SP_W'(mag >> (FB + 1))};
      end
   endfunction

   ggdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   assign dx = signed'(ggdc_pkg::DX_W'(cfg.goal_x) - ggdc_pkg::DX_W'(req_bus.pos_x));
   assign dy = signed'(ggdc_pkg::DX_W'(cfg.goal_y) - ggdc_pkg::DX_W'(req_bus.pos_y));

   ggdc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (go_cordic),
      .dx    (dx),
      .dy    (dy),
      .res   (cres)
   );

   assign req_bus.ready         = req_ready;
   assign req_acc               = req_bus.valid && req_ready;
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.status        = out_status_ff;
   assign rsp_bus.left_forward  = out_lf_ff;
   assign rsp_bus.left_mag      = out_ls_ff;
   assign rsp_bus.right_forward = out_rf_ff;
   assign rsp_bus.right_mag     = out_rs_ff;

   // shared multiplier
   always_comb begin
      case (state_ff)
         ggdc_pkg::ST_MAG: begin
            mul_a = cres.x_mag;
            mul_b = INV_GAIN;
         end
         ggdc_pkg::ST_VMUL: begin
            mul_a = signed'(XY_W'(dist_ff));
            mul_b = signed'(MB_W'(cfg.distance_gain));
         end
         ggdc_pkg::ST_WMUL: begin
            mul_a = XY_W'(err_ff);
            mul_b = signed'(MB_W'(cfg.heading_gain));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign dist_full = (prod_ff + MAG_HALF) >>> ggdc_pkg::MAG_SHIFT;
   assign dist_c    = DIST_W'(dist_full);
   assign stop_c    = DIST_W'(cfg.stop_radius) << FB;
   assign arrived   = dist_c < stop_c;
   assign bearing   = (cres.z_ang + ANG_HALF) >>> ggdc_pkg::ANG_SHIFT;
   assign hd_c      = signed'(ERR_W'(hd_ff)) <<< FB;
   assign scaled    = (prod_ff + GAIN_HALF) >>> ggdc_pkg::GAIN_SHIFT;
   assign vmax_c    = signed'(PROD_W'(cfg.max_linear_speed)) <<< FB;
   assign wmax_c    = signed'(PROD_W'(cfg.max_turn_rate)) <<< FB;

   always_comb begin
      if (scaled > wmax_c) begin
         w_c = W_W'(wmax_c);
      end else if (scaled < -wmax_c) begin
         w_c = W_W'(-wmax_c);
      end else begin
         w_c = W_W'(scaled);
      end
   end

   assign left2     = (WH_W'(v_ff) <<< 1) - WH_W'(w_c);
   assign right2    = (WH_W'(v_ff) <<< 1) + WH_W'(w_c);
   assign left_enc  = wheel_enc(left2);
   assign right_enc = wheel_enc(right2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ggdc_pkg::ST_IDLE: begin
            if (go_cordic) begin
               state_in = ggdc_pkg::ST_CORDIC;
            end else if (req_acc) begin
               state_in = ggdc_pkg::ST_DONE;
            end
         end
         ggdc_pkg::ST_CORDIC: begin
            if (cres.done) begin
               state_in = ggdc_pkg::ST_MAG;
            end
         end
         ggdc_pkg::ST_MAG:   state_in = ggdc_pkg::ST_CHECK;
         ggdc_pkg::ST_CHECK: state_in = arrived ? ggdc_pkg::ST_DONE : ggdc_pkg::ST_WRAP;
         ggdc_pkg::ST_WRAP: begin
            if (err_ff <= ERR_HALF && err_ff >= -ERR_HALF) begin
               state_in = ggdc_pkg::ST_VMUL;
            end
         end
         ggdc_pkg::ST_VMUL:  state_in = ggdc_pkg::ST_WMUL;
         ggdc_pkg::ST_WMUL:  state_in = ggdc_pkg::ST_MIX;
         ggdc_pkg::ST_MIX:   state_in = ggdc_pkg::ST_DONE;
         ggdc_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = ggdc_pkg::ST_IDLE;
            end
         end
         default: state_in = ggdc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      go_cordic = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ggdc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            go_cordic = req_bus.valid && (req_bus.command == ggdc_pkg::CMD_POSE)
                        && armed_ff && req_bus.on_mat;
         end
         ggdc_pkg::ST_DONE: out_load = !out_valid_ff || rsp_bus.ready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      armed_in      = armed_ff;
      hd_in         = hd_ff;
      prod_in       = prod_ff;
      dist_in       = dist_ff;
      err_in        = err_ff;
      v_in          = v_ff;
      res_status_in = res_status_ff;
      res_lf_in     = res_lf_ff;
      res_ls_in     = res_ls_ff;
      res_rf_in     = res_rf_ff;
      res_rs_in     = res_rs_ff;
      out_status_in = out_status_ff;
      out_lf_in     = out_lf_ff;
      out_ls_in     = out_ls_ff;
      out_rf_in     = out_rf_ff;
      out_rs_in     = out_rs_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      case (state_ff)
         ggdc_pkg::ST_IDLE: begin
            if (req_acc) begin
               hd_in     = req_bus.heading_deg;
               res_lf_in = 1'b1;
               res_ls_in = '0;
               res_rf_in = 1'b1;
               res_rs_in = '0;
               case (req_bus.command)
                  ggdc_pkg::CMD_ARM: begin
                     armed_in      = 1'b1;
                     res_status_in = ggdc_pkg::STAT_ACK;
                  end
                  ggdc_pkg::CMD_CLEAR: begin
                     armed_in      = 1'b0;
                     res_status_in = ggdc_pkg::STAT_ACK;
                  end
                  ggdc_pkg::CMD_POSE: begin
                     if (!armed_ff) begin
                        res_status_in = ggdc_pkg::STAT_NO_GOAL;
                     end else if (!req_bus.on_mat) begin
                        res_status_in = ggdc_pkg::STAT_OFF_MAT;
                     end else begin
                        res_status_in = ggdc_pkg::STAT_DRIVING;
                     end
                  end
                  default: res_status_in = ggdc_pkg::STAT_ACK;
               endcase
            end
         end
         ggdc_pkg::ST_MAG: prod_in = mul_p;
         ggdc_pkg::ST_CHECK: begin
            dist_in = dist_c;
            err_in  = ERR_W'(bearing) - hd_c;
            if (arrived) begin
               armed_in      = 1'b0;
               res_status_in = ggdc_pkg::STAT_ARRIVED;
            end
         end
         ggdc_pkg::ST_WRAP: begin
            if (err_ff > ERR_HALF) begin
               err_in = err_ff - ERR_FULL;
            end else if (err_ff < -ERR_HALF) begin
               err_in = err_ff + ERR_FULL;
            end else begin
               err_in = -err_ff;
            end
         end
         ggdc_pkg::ST_VMUL: prod_in = mul_p;
         ggdc_pkg::ST_WMUL: begin
            prod_in = mul_p;
            v_in    = (scaled > vmax_c) ? V_W'(vmax_c) : V_W'(scaled);
         end
         ggdc_pkg::ST_MIX: begin
            res_status_in = ggdc_pkg::STAT_DRIVING;
            res_lf_in     = left_enc[SP_W];
            res_ls_in     = left_enc[SP_W-1:0];
            res_rf_in     = right_enc[SP_W];
            res_rs_in     = right_enc[SP_W-1:0];
         end
         ggdc_pkg::ST_DONE: begin
            if (out_load) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_lf_in     = res_lf_ff;
               out_ls_in     = res_ls_ff;
               out_rf_in     = res_rf_ff;
               out_rs_in     = res_rs_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ggdc_pkg::ST_IDLE;
         armed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         out_valid_ff <= out_valid_in;
      end
      hd_ff         <= hd_in;
      prod_ff       <= prod_in;
      dist_ff       <= dist_in;
      err_ff        <= err_in;
      v_ff          <= v_in;
      res_status_ff <= res_status_in;
      res_lf_ff     <= res_lf_in;
      res_ls_ff     <= res_ls_in;
      res_rf_ff     <= res_rf_in;
      res_rs_ff     <= res_rs_in;
      out_status_ff <= out_status_in;
      out_lf_ff     <= out_lf_in;
      out_ls_ff     <= out_ls_in;
      out_rf_ff     <= out_rf_in;
      out_rs_ff     <= out_rs_in;
   end

endmodule

@@ design/ggdc_csr.sv @@
module ggdc_csr (
   input  logic              clock,
   input  logic              reset,
   ggdc_csr_if.sink          csr_bus,
   output ggdc_pkg::cfg_type cfg
);

   ggdc_pkg::cfg_type cfg_ff;
   ggdc_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            ggdc_pkg::REG_MAX_LIN:
               cfg_in.max_linear_speed = ggdc_pkg::LIN_W'(csr_bus.data);
            ggdc_pkg::REG_MAX_TURN:
               cfg_in.max_turn_rate = ggdc_pkg::TURN_W'(csr_bus.data);
            ggdc_pkg::REG_DIST_GAIN:
               cfg_in.distance_gain = ggdc_pkg::GAIN_W'(csr_bus.data);
            ggdc_pkg::REG_HEAD_GAIN:
               cfg_in.heading_gain = ggdc_pkg::GAIN_W'(csr_bus.data);
            ggdc_pkg::REG_GOAL_X:
               cfg_in.goal_x = ggdc_pkg::POS_W'(csr_bus.data);
            ggdc_pkg::REG_GOAL_Y:
               cfg_in.goal_y = ggdc_pkg::POS_W'(csr_bus.data);
            ggdc_pkg::REG_STOP_RAD:
               cfg_in.stop_radius = ggdc_pkg::POS_W'(csr_bus.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_linear_speed <= ggdc_pkg::LIN_W'(100);
         cfg_ff.max_turn_rate    <= ggdc_pkg::TURN_W'(100);
         cfg_ff.distance_gain    <= ggdc_pkg::GAIN_W'(256);
         cfg_ff.heading_gain     <= ggdc_pkg::GAIN_W'(256);
         cfg_ff.goal_x           <= '0;
         cfg_ff.goal_y           <= '0;
         cfg_ff.stop_radius      <= ggdc_pkg::POS_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/ggdc_cordic.sv @@
module ggdc_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ggdc_pkg::DX_W-1:0]    dx,
   input  logic signed [ggdc_pkg::DX_W-1:0]    dy,
   output ggdc_pkg::cordic_res_type            res
);

   localparam int XY_W  = ggdc_pkg::XY_W;
   localparam int Z_W   = ggdc_pkg::Z_W;
   localparam int CNT_W = ggdc_pkg::CNT_W;
   localparam int PRE   = ggdc_pkg::FRAC_BITS + ggdc_pkg::GUARD_BITS;
   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(ggdc_pkg::QUARTER_Z);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    zero_ff, zero_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [XY_W-1:0]  x_ff, x_in;
   logic signed [XY_W-1:0]  y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;

   logic signed [XY_W-1:0]  x0;
   logic signed [XY_W-1:0]  y0;
   logic signed [XY_W-1:0]  xs;
   logic signed [XY_W-1:0]  ys;
   logic signed [Z_W-1:0]   dz;

   assign x0 = XY_W'(dx) <<< PRE;
   assign y0 = XY_W'(dy) <<< PRE;
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign dz = signed'(Z_W'(ggdc_pkg::atan_q16(ggdc_pkg::ATAN_IDX_W'(cnt_ff))));

   assign res.done  = done_ff;
   assign res.x_mag = x_ff;
   assign res.z_ang = z_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         zero_in = (dx == '0) && (dy == '0);
         x_in    = x0;
         y_in    = y0;
         z_in    = '0;
         // rotate into the right half plane first
         if (dx[ggdc_pkg::DX_W-1]) begin
            if (!dy[ggdc_pkg::DX_W-1]) begin
               x_in = y0;
               y_in = -x0;
               z_in = Z_QUARTER;
            end else begin
               x_in = -y0;
               y_in = x0;
               z_in = -Z_QUARTER;
            end
         end
      end else if (busy_ff) begin
         if (!y_ff[XY_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            if (!zero_ff) begin
               z_in = z_ff + dz;
            end
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            if (!zero_ff) begin
               z_in = z_ff - dz;
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ggdc_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         zero_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         zero_ff <= zero_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule
